/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl, clocked on clk with rst_n low disabling
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant
`define ETOK_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ETOK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ETOK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/etok_pkg.sv */
package etok_pkg;

  // token kinds as seen on the result channel
  typedef enum logic [3:0] {
    KIND_NUM     = 4'd0,
    KIND_VAR     = 4'd1,
    KIND_CONST   = 4'd2,
    KIND_OPEN    = 4'd3,
    KIND_CLOSE   = 4'd4,
    KIND_ADD     = 4'd5,
    KIND_MUL     = 4'd6,
    KIND_POW     = 4'd7,
    KIND_UNKNOWN = 4'd8,
    KIND_END     = 4'd9
  } token_kind_e;

  // token being gathered over several characters
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_NUM   = 2'd1,
    PEND_IDENT = 2'd2
  } pend_kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    token_kind_e token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic [7:0]  lead_char;
    logic        final_token;
  } out_item_t;

  localparam int unsigned MAX_RESULTS = 3;

  // results caused by one character, oldest in slot 0
  typedef struct packed {
    logic [1:0]                  count;
    out_item_t [MAX_RESULTS-1:0] tok;
  } etok_emit_t;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_I      = 8'h69;

  // constant match flag bits
  localparam int unsigned FLAG_E  = 0;
  localparam int unsigned FLAG_PI = 1;
  localparam int unsigned FLAG_I  = 2;

endpackage

/* hw/rtl/expression_tokenizer_unit.sv */
// channel | dir | handshake              | payload
// --------+-----+------------------------+--------------------------------------
// in      | in  | in_valid / in_ready    | in_data : in_item_t (char, end flag)
// out     | out | out_valid / out_ready  | out_data : out_item_t (one token)
// cfg     | in  | cfg_valid / cfg_ready  | cfg_data : drop_unknown bit
//
// a character is lexed in the cycle of its transfer and its results land in a
// three-slot result register; while out_ready is high, one character transfers
// every cycle if each has at most one result, and a character with k > 1 results
// holds the input until the register, draining one token a cycle, is down to one.
// synchronous active-low reset clears the lexer state, the result count and
// drop_unknown; out_ready low stalls the input whenever the register holds a
// token. cfg_ready is always high.
module expression_tokenizer_unit
  import etok_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  `include "assert_macros.svh"

  logic                        drop_unknown_r;
  logic [1:0]                  cnt_r, cnt_nxt;
  out_item_t [MAX_RESULTS-1:0] res_r, res_nxt;
  etok_emit_t                  emit;
  logic                        accept, pop;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_unknown_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      drop_unknown_r <= cfg_data;
    end
  end

  // handshakes
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = res_r[0];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign accept    = in_valid && in_ready;

  etok_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_data),
    .drop_unknown(drop_unknown_r),
    .emit        (emit)
  );

  // result register: load on input transfer, shift down on output transfer
  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      res_nxt = emit.tok;
      cnt_nxt = emit.count;
    end else if (pop) begin
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // checks
  `ETOK_ASSERT_IMP(a_last_is_final, out_valid && cnt_r == 2'd1, out_data.final_token, "last buffered token not marked final")
  `ETOK_ASSERT_IMP(a_end_shape, out_valid && out_data.token_kind == KIND_END, out_data.final_token && out_data.token_length == 16'd0, "end token malformed")
  `ETOK_ASSERT_NXT(a_end_emits, accept && in_data.end_of_text, out_valid, "end of text gave no result")
  `ETOK_ASSERT_NXT(a_pop_shift, pop && !accept && cnt_r > 2'd1, out_data == $past(res_r[1]), "result register did not shift")

endmodule

/* hw/rtl/etok_lexer.sv */
module etok_lexer
  import etok_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  input  logic       drop_unknown,
  output etok_emit_t emit
);

  localparam int unsigned PW = POSITION_BITS;
  localparam logic [PW-1:0] ONE = PW'(1);
  localparam logic [PW-1:0] TWO = PW'(2);

  // lexer state
  logic [PW-1:0] pos_r,   pos_nxt;
  pend_kind_e    pend_r,  pend_nxt;
  logic          dot_r,   dot_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [PW-1:0] len_r,   len_nxt;
  logic [7:0]    lead_r,  lead_nxt;
  logic [2:0]    flags_r, flags_nxt;

  // state after the character, before the end-of-text clear
  pend_kind_e    mid_kind;
  logic          mid_dot;
  logic [PW-1:0] mid_start;
  logic [PW-1:0] mid_len;
  logic [7:0]    mid_lead;
  logic [2:0]    mid_flags;

  logic [7:0]    c;
  logic          last;
  logic          is_dig, is_alp, is_spc;
  logic          consumed, start_new, plain;
  logic          f_valid, i_valid, l_valid, b_valid;
  token_kind_e   i_kind;
  logic [PW-1:0] pos_inc;
  out_item_t     f_tok, i_tok, l_tok, e_tok, b_tok;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == '1) ? v : v + ONE;
  endfunction

  function automatic logic [15:0] to16(input logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic token_kind_e pend_token_kind(input pend_kind_e k, input logic [2:0] fl,
                                                  input logic [PW-1:0] len);
    token_kind_e r;
    if (k == PEND_NUM) begin
      r = KIND_NUM;
    end else if (((fl[FLAG_E] || fl[FLAG_I]) && len == ONE) || (fl[FLAG_PI] && len == TWO)) begin
      r = KIND_CONST;
    end else begin
      r = KIND_VAR;
    end
    return r;
  endfunction

  function automatic out_item_t mk_tok(input token_kind_e k, input logic [15:0] s,
                                       input logic [15:0] l, input logic [7:0] ch);
    out_item_t t;
    t.token_kind   = k;
    t.start_pos    = s;
    t.token_length = l;
    t.lead_char    = ch;
    t.final_token  = 1'b0;
    return t;
  endfunction

  assign c    = item.char_code;
  assign last = item.end_of_text;

  // character classes
  assign is_dig = (c >= CH_0) && (c <= CH_9);
  assign is_alp = ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  assign is_spc = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  // extend or flush the pending token, then start a new one
  always_comb begin
    mid_kind  = pend_r;
    mid_dot   = dot_r;
    mid_start = start_r;
    mid_len   = len_r;
    mid_lead  = lead_r;
    mid_flags = flags_r;
    consumed  = 1'b0;
    unique case (pend_r)
      PEND_NUM: begin
        if (is_dig || (c == CH_DOT && !dot_r)) begin
          consumed = 1'b1;
          mid_len  = sat_inc(len_r);
          if (c == CH_DOT) begin
            mid_dot = 1'b1;
          end
        end
      end
      PEND_IDENT: begin
        if (is_alp || is_dig || c == CH_UNDER) begin
          consumed           = 1'b1;
          mid_len            = sat_inc(len_r);
          mid_flags          = '0;
          mid_flags[FLAG_PI] = (len_r == ONE) && (c == CH_I) && flags_r[FLAG_PI];
        end
      end
      default: ;
    endcase

    f_valid = (pend_r != PEND_NONE) && !consumed;
    if (f_valid) begin
      mid_kind  = PEND_NONE;
      mid_dot   = 1'b0;
      mid_len   = '0;
      mid_flags = '0;
    end

    start_new = !consumed && (is_alp || is_dig);
    if (start_new) begin
      mid_kind           = is_alp ? PEND_IDENT : PEND_NUM;
      mid_start          = pos_r;
      mid_len            = ONE;
      mid_lead           = c;
      mid_dot            = 1'b0;
      mid_flags          = '0;
      mid_flags[FLAG_E]  = (c == CH_E);
      mid_flags[FLAG_PI] = (c == CH_P);
      mid_flags[FLAG_I]  = (c == CH_I);
    end
  end

  // single-character tokens
  always_comb begin
    case (c)
      CH_LPAREN:         i_kind = KIND_OPEN;
      CH_RPAREN:         i_kind = KIND_CLOSE;
      CH_PLUS, CH_MINUS: i_kind = KIND_ADD;
      CH_STAR, CH_SLASH: i_kind = KIND_MUL;
      CH_CARET:          i_kind = KIND_POW;
      default:           i_kind = KIND_UNKNOWN;
    endcase
  end

  assign plain   = !consumed && !is_spc && !is_alp && !is_dig;
  assign i_valid = plain && ((i_kind != KIND_UNKNOWN) || !drop_unknown);
  assign l_valid = last && (mid_kind != PEND_NONE);
  assign pos_inc = sat_inc(pos_r);

  // candidate results in emission order
  assign f_tok = mk_tok(pend_token_kind(pend_r, flags_r, len_r), to16(start_r), to16(len_r),
                        lead_r);
  assign i_tok = mk_tok(i_kind, to16(pos_r), 16'd1, c);
  assign l_tok = mk_tok(pend_token_kind(mid_kind, mid_flags, mid_len), to16(mid_start),
                        to16(mid_len), mid_lead);
  assign e_tok = mk_tok(KIND_END, to16(pos_inc), 16'd0, 8'd0);

  // a single token and the end-of-text flush never occur together
  assign b_valid = i_valid || l_valid;
  assign b_tok   = i_valid ? i_tok : l_tok;

  // pack the valid results into the low slots and mark the last one
  always_comb begin
    emit.count  = {1'b0, f_valid} + {1'b0, b_valid} + {1'b0, last};
    emit.tok[0] = f_valid ? f_tok : (b_valid ? b_tok : e_tok);
    emit.tok[1] = f_valid ? (b_valid ? b_tok : e_tok) : e_tok;
    emit.tok[2] = e_tok;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      emit.tok[k].final_token = (2'(k) == emit.count - 2'd1);
    end
  end

  // next state, cleared for a new text after the end token
  always_comb begin
    if (last) begin
      pos_nxt   = '0;
      pend_nxt  = PEND_NONE;
      dot_nxt   = 1'b0;
      start_nxt = '0;
      len_nxt   = '0;
      lead_nxt  = '0;
      flags_nxt = '0;
    end else begin
      pos_nxt   = pos_inc;
      pend_nxt  = mid_kind;
      dot_nxt   = mid_dot;
      start_nxt = mid_start;
      len_nxt   = mid_len;
      lead_nxt  = mid_lead;
      flags_nxt = mid_flags;
    end
  end

  // state registers, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      pend_r  <= PEND_NONE;
      dot_r   <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      lead_r  <= '0;
      flags_r <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      dot_r   <= dot_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      lead_r  <= lead_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule
